[rtl/core/mbg_pkg.sv]
// ----------------------------------------------------------------------------
// mbg_pkg: shared types and constants for the Mandelbrot grid unit
// Fixed-point format, iteration limits, config register indexes and the
// word that travels down the chain of iteration cells.
// ----------------------------------------------------------------------------
package mbg_pkg;

  // Q4.28 signed fixed point
  localparam int unsigned FRAC_BITS = 28;
  // most z*z+c steps per pixel, one cell each
  localparam int unsigned MAX_ITER  = 64;
  // width of the iteration count register and the cell index
  localparam int unsigned CNT_W     = 7;
  // point width
  localparam int unsigned PT_W      = 32;
  // z is held wide enough for one unchecked step out of the |z|<=2 box
  localparam int unsigned ZW        = 34;
  // multiplier operand: an in-box z fits 31 bits signed
  localparam int unsigned OP_W      = 31;
  // pixel index width
  localparam int unsigned IDX_W     = 12;
  // step register width
  localparam int unsigned STEP_W    = 31;

  // config register indexes
  typedef enum logic [2:0] {
    CFG_REAL_START = 3'd0,
    CFG_REAL_STEP  = 3'd1,
    CFG_IMAG_START = 3'd2,
    CFG_IMAG_STEP  = 3'd3,
    CFG_ITER_COUNT = 3'd4
  } cfg_idx_e;

  // word handed from cell to cell
  typedef struct packed {
    logic                    valid;
    logic                    esc;    // sticky escape
    logic                    fresh;  // z was just produced by a step, not yet checked
    logic signed [ZW-1:0]    zr;
    logic signed [ZW-1:0]    zi;
    logic signed [PT_W-1:0]  cr;
    logic signed [PT_W-1:0]  ci;
  } cell_word_t;

endpackage

[rtl/core/mbg_map.sv]
// ----------------------------------------------------------------------------
// mbg_map: pixel index to complex point
// Two stages: index times step, then start plus offset saturated to 32 bits.
// Emits the first chain word with z = 0.
// ----------------------------------------------------------------------------
module mbg_map (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [mbg_pkg::IDX_W-1:0]           column_i,
  input  logic [mbg_pkg::IDX_W-1:0]           row_i,
  input  logic signed [mbg_pkg::PT_W-1:0]     real_start_i,
  input  logic [mbg_pkg::STEP_W-1:0]          real_step_i,
  input  logic signed [mbg_pkg::PT_W-1:0]     imag_start_i,
  input  logic [mbg_pkg::STEP_W-1:0]          imag_step_i,
  output mbg_pkg::cell_word_t                 word_o
);

  localparam int unsigned PROD_W = mbg_pkg::IDX_W + mbg_pkg::STEP_W;
  localparam int unsigned SUM_W  = PROD_W + 2;
  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(32'sh7fff_ffff);
  localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(-33'sh0_8000_0000);

  logic              v1_q;
  logic [PROD_W-1:0] off_r_q, off_i_q;
  logic signed [SUM_W-1:0] sum_r, sum_i;
  logic signed [mbg_pkg::PT_W-1:0] cr_d, ci_d;
  mbg_pkg::cell_word_t word_q;

  // stage 1: offsets
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      off_r_q <= PROD_W'(column_i) * PROD_W'(real_step_i);
      off_i_q <= PROD_W'(row_i) * PROD_W'(imag_step_i);
    end
  end

  // stage 2: add start and saturate
  always_comb begin
    sum_r = SUM_W'(real_start_i) + $signed({2'b00, off_r_q});
    sum_i = SUM_W'(imag_start_i) + $signed({2'b00, off_i_q});
    if (sum_r > SAT_MAX)      cr_d = mbg_pkg::PT_W'(SAT_MAX);
    else if (sum_r < SAT_MIN) cr_d = mbg_pkg::PT_W'(SAT_MIN);
    else                      cr_d = sum_r[mbg_pkg::PT_W-1:0];
    if (sum_i > SAT_MAX)      ci_d = mbg_pkg::PT_W'(SAT_MAX);
    else if (sum_i < SAT_MIN) ci_d = mbg_pkg::PT_W'(SAT_MIN);
    else                      ci_d = sum_i[mbg_pkg::PT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
    end else if (en_i) begin
      word_q.valid <= v1_q;
      word_q.esc   <= 1'b0;
      word_q.fresh <= 1'b0;
      word_q.zr    <= '0;
      word_q.zi    <= '0;
      word_q.cr    <= cr_d;
      word_q.ci    <= ci_d;
    end
  end

  assign word_o = word_q;

endmodule

[rtl/core/mbg_cell.sv]
// ----------------------------------------------------------------------------
// mbg_cell: one z = z*z + c step
// Stage A checks the box |re|,|im| <= 2 and registers the three products.
// Stage B checks |z|^2 > 4 from the squares and forms the next z.
// A cell whose index is at or past the iteration count only checks.
// ----------------------------------------------------------------------------
module mbg_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic [mbg_pkg::CNT_W-1:0]  iter_lim_i,
  input  logic [mbg_pkg::CNT_W-1:0]  cell_idx_i,
  input  mbg_pkg::cell_word_t        word_i,
  output mbg_pkg::cell_word_t        word_o
);

  localparam int unsigned ZW   = mbg_pkg::ZW;
  localparam int unsigned OP_W = mbg_pkg::OP_W;
  localparam int unsigned PW   = 2 * OP_W;
  localparam int unsigned MW   = PW + 1;
  localparam int unsigned WW   = 64;
  localparam logic signed [ZW-1:0] TWO_Q     = ZW'(2) << mbg_pkg::FRAC_BITS;
  localparam logic signed [ZW-1:0] NEG_TWO_Q = -TWO_Q;
  localparam logic [MW-1:0]        FOUR_SQ   = MW'(4) << (2 * mbg_pkg::FRAC_BITS);

  logic box_out, esc_a;
  logic signed [OP_W-1:0] op_r, op_i;

  logic                          va_q, esc_a_q, fresh_a_q;
  logic signed [ZW-1:0]          zr_a_q, zi_a_q;
  logic signed [mbg_pkg::PT_W-1:0] cr_a_q, ci_a_q;
  logic signed [PW-1:0]          sq_r_q, sq_i_q, x_q;

  logic [MW-1:0]        mag;
  logic                 esc_b, step_b;
  logic signed [WW-1:0] re_full, im_full;
  mbg_pkg::cell_word_t  word_q;

  // stage A: box check, multiplier operands
  always_comb begin
    box_out = (word_i.zr > TWO_Q) || (word_i.zr < NEG_TWO_Q) ||
              (word_i.zi > TWO_Q) || (word_i.zi < NEG_TWO_Q);
    esc_a   = word_i.esc || (word_i.fresh && box_out);
    op_r    = esc_a ? '0 : word_i.zr[OP_W-1:0];
    op_i    = esc_a ? '0 : word_i.zi[OP_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_i) begin
      va_q <= word_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      esc_a_q   <= esc_a;
      fresh_a_q <= word_i.fresh;
      zr_a_q    <= word_i.zr;
      zi_a_q    <= word_i.zi;
      cr_a_q    <= word_i.cr;
      ci_a_q    <= word_i.ci;
      sq_r_q    <= op_r * op_r;
      sq_i_q    <= op_i * op_i;
      x_q       <= op_r * op_i;
    end
  end

  // stage B: magnitude check and next z (arithmetic shift = floor)
  always_comb begin
    mag     = MW'(unsigned'(sq_r_q)) + MW'(unsigned'(sq_i_q));
    esc_b   = esc_a_q || (fresh_a_q && (mag > FOUR_SQ));
    step_b  = !esc_b && (cell_idx_i < iter_lim_i);
    re_full = ((WW'(sq_r_q) - WW'(sq_i_q)) >>> mbg_pkg::FRAC_BITS) + WW'(cr_a_q);
    im_full = ((WW'(x_q) <<< 1) >>> mbg_pkg::FRAC_BITS) + WW'(ci_a_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
    end else if (en_i) begin
      word_q.valid <= va_q;
      word_q.esc   <= esc_b;
      word_q.fresh <= step_b;
      word_q.zr    <= step_b ? re_full[ZW-1:0] : zr_a_q;
      word_q.zi    <= step_b ? im_full[ZW-1:0] : zi_a_q;
      word_q.cr    <= cr_a_q;
      word_q.ci    <= ci_a_q;
    end
  end

  assign word_o = word_q;

endmodule

[rtl/core/mandelbrot_membership_grid_unit.sv]
// ----------------------------------------------------------------------------
// mandelbrot_membership_grid_unit: Mandelbrot escape test per pixel
// Maps (column, row) to c and runs up to 64 z*z+c steps in a cell chain.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one word per pixel:
//   column_i, row_i. Output channel (out_valid_o / out_stall_i) returns
//   point_real_o, point_imag_o (c in Q4.28, saturated) and inside_res_o
//   (1 when |z| <= 2 after the configured number of steps).
//   Config channel (cfg_valid_i / cfg_ready_o) writes register cfg_index_i
//   with cfg_data_i; it is always ready. Write only while no pixel is in
//   flight. Counts above 64 act as 64.
//   The pipeline is 2 mapping stages plus 65 cells of 2 stages
//   (64 step cells and one final check cell). A new pixel can enter every
//   cycle unless the output stalls; the chain of cells is a fixed-length
//   pipeline, one step per cell. When the receiver stalls a valid result,
//   the whole chain holds and in_stall_o rises in the same cycle.
//   Reset clears all valid bits and loads the default view (-2.0, -1.5,
//   step 2^-10, 64 iterations).
// ----------------------------------------------------------------------------
module mandelbrot_membership_grid_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // config write
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [2:0]                         cfg_index_i,
  input  logic [31:0]                        cfg_data_i,
  // pixel in
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [mbg_pkg::IDX_W-1:0]          column_i,
  input  logic [mbg_pkg::IDX_W-1:0]          row_i,
  // result out
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [mbg_pkg::PT_W-1:0]    point_real_o,
  output logic signed [mbg_pkg::PT_W-1:0]    point_imag_o,
  output logic                               inside_res_o
);

  localparam int unsigned NCELL = mbg_pkg::MAX_ITER + 1;

  logic signed [mbg_pkg::PT_W-1:0]   real_start_q, imag_start_q;
  logic [mbg_pkg::STEP_W-1:0]        real_step_q, imag_step_q;
  logic [mbg_pkg::CNT_W-1:0]         iter_cnt_q, iter_lim;
  logic                              en;
  mbg_pkg::cell_word_t               chain [NCELL+1];

  // config registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      real_start_q <= -32'sd536870912;
      real_step_q  <= 31'd262144;
      imag_start_q <= -32'sd402653184;
      imag_step_q  <= 31'd262144;
      iter_cnt_q   <= mbg_pkg::CNT_W'(mbg_pkg::MAX_ITER);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (mbg_pkg::cfg_idx_e'(cfg_index_i))
        mbg_pkg::CFG_REAL_START: real_start_q <= cfg_data_i;
        mbg_pkg::CFG_REAL_STEP:  real_step_q  <= cfg_data_i[mbg_pkg::STEP_W-1:0];
        mbg_pkg::CFG_IMAG_START: imag_start_q <= cfg_data_i;
        mbg_pkg::CFG_IMAG_STEP:  imag_step_q  <= cfg_data_i[mbg_pkg::STEP_W-1:0];
        mbg_pkg::CFG_ITER_COUNT: iter_cnt_q   <= cfg_data_i[mbg_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the count to the number of step cells
  assign iter_lim = (iter_cnt_q > mbg_pkg::CNT_W'(mbg_pkg::MAX_ITER)) ?
                    mbg_pkg::CNT_W'(mbg_pkg::MAX_ITER) : iter_cnt_q;

  // whole chain advances unless a result is held at the output
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  mbg_map u_map (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (in_valid_i),
    .column_i     (column_i),
    .row_i        (row_i),
    .real_start_i (real_start_q),
    .real_step_i  (real_step_q),
    .imag_start_i (imag_start_q),
    .imag_step_i  (imag_step_q),
    .word_o       (chain[0])
  );

  // step cells, then one check-only cell (its index never below the count)
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    mbg_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (en),
      .iter_lim_i (iter_lim),
      .cell_idx_i (mbg_pkg::CNT_W'(k)),
      .word_i     (chain[k]),
      .word_o     (chain[k+1])
    );
  end

  // last cell register is the output register
  assign out_valid_o  = chain[NCELL].valid;
  assign point_real_o = chain[NCELL].cr;
  assign point_imag_o = chain[NCELL].ci;
  assign inside_res_o = !chain[NCELL].esc;

endmodule
